FILE: design/tfr_pkg.sv
// Shared types and constants for the texel format converter.
package tfr_pkg;

    localparam int MAX_DIM    = 1024;
    localparam int MIN_DIM    = 8;
    localparam int DIM_W      = 11;
    localparam int POS_W      = $clog2(MAX_DIM);
    localparam int IDX_W      = 20;
    localparam int PAD_STEPS  = $clog2(MAX_DIM) - $clog2(MIN_DIM);
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int PAL_DEPTH  = 256;
    localparam int PAL_AW     = $clog2(PAL_DEPTH);
    localparam int CFG_AW     = 2;

    typedef enum logic [1:0] {
        FMT_RGBA32 = 2'd0,
        FMT_RGBA16 = 2'd1,
        FMT_CI8    = 2'd2,
        FMT_IA8    = 2'd3
    } fmt_t;

    typedef enum logic {
        FUNC_PAL_WRITE = 1'b0,
        FUNC_TEXEL     = 1'b1
    } func_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_FORMAT = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_idx_t;

    // One queued operation; palette writes carry {colour, index} in data
    typedef struct packed {
        func_t             func;
        logic              status;
        logic              last;
        logic [IDX_W-1:0]  pixel_index;
        fmt_t              fmt;
        logic [31:0]       data;
    } entry_t;

endpackage

FILE: design/texel_format_to_rgba8_top.sv
// Top level of the texel format to RGBA8 converter.
// A texel passes the queue, the palette read stage and the output register to m_valid.
// Throughput: one item per cycle unless m_ready stalls; four-entry queue, two back-end stages.
// Palette writes go through the queue to the back-end store; no transfer on the result side.
// Reset (aresetn, synchronous, active low) empties queue and pipeline, zeroes the raster
// position and sets format rgba32, size 1 x 1; palette contents are not cleared.
module texel_format_to_rgba8_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [tfr_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [tfr_pkg::DIM_W-1:0]    cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [7:0]                   s_palette_index,
    input  logic [15:0]                  s_palette_color,
    input  logic [31:0]                  s_texel_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tfr_pkg::IDX_W-1:0]    m_pixel_index,
    output logic [7:0]                   m_red,
    output logic [7:0]                   m_green,
    output logic [7:0]                   m_blue,
    output logic [7:0]                   m_alpha,
    output logic                         m_last_texel,
    output logic                         m_status
);

    logic             push;
    logic             push_ready;
    tfr_pkg::entry_t  push_entry;
    logic             pop_valid;
    logic             pop_ready;
    tfr_pkg::entry_t  pop_entry;

    tfr_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_palette_index (s_palette_index),
        .s_palette_color (s_palette_color),
        .s_texel_data    (s_texel_data),
        .q_push          (push),
        .q_entry         (push_entry),
        .q_ready         (push_ready)
    );

    tfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    tfr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (pop_valid),
        .q_entry       (pop_entry),
        .q_ready       (pop_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_index (m_pixel_index),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_alpha       (m_alpha),
        .m_last_texel  (m_last_texel),
        .m_status      (m_status)
    );

endmodule

FILE: design/tfr_front.sv
// Front end: config registers, raster position tracking and item classification.
module tfr_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [tfr_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [tfr_pkg::DIM_W-1:0]    cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [7:0]                   s_palette_index,
    input  logic [15:0]                  s_palette_color,
    input  logic [31:0]                  s_texel_data,
    output logic                         q_push,
    output tfr_pkg::entry_t              q_entry,
    input  logic                         q_ready
);

    function automatic logic [tfr_pkg::DIM_W-1:0] pad_of(input logic [tfr_pkg::DIM_W-1:0] w);
        logic [tfr_pkg::DIM_W-1:0] p;
        p = tfr_pkg::DIM_W'(tfr_pkg::MIN_DIM);
        for (int i = 0; i < tfr_pkg::PAD_STEPS; i++) begin
            if (p < w) begin
                p = p << 1;
            end
        end
        return p;
    endfunction

    tfr_pkg::fmt_t                fmt_reg, fmt_next;
    logic [tfr_pkg::DIM_W-1:0]    width_reg, width_next;
    logic [tfr_pkg::DIM_W-1:0]    height_reg, height_next;
    logic [tfr_pkg::DIM_W-1:0]    pad_reg, pad_next;
    logic [tfr_pkg::POS_W-1:0]    col_reg, col_next;
    logic [tfr_pkg::POS_W-1:0]    row_reg, row_next;
    logic [tfr_pkg::IDX_W-1:0]    base_reg, base_next;

    logic accept;
    logic is_texel;
    logic size_err;
    logic col_last;
    logic row_last;

    assign s_ready  = q_ready;
    assign accept   = s_valid && s_ready;
    assign is_texel = (tfr_pkg::func_t'(s_func) == tfr_pkg::FUNC_TEXEL);
    assign size_err = (width_reg == '0) || (width_reg > tfr_pkg::DIM_W'(tfr_pkg::MAX_DIM))
                   || (height_reg == '0) || (height_reg > tfr_pkg::DIM_W'(tfr_pkg::MAX_DIM));
    assign col_last = ({1'b0, col_reg} + tfr_pkg::DIM_W'(1)) >= width_reg;
    assign row_last = ({1'b0, row_reg} + tfr_pkg::DIM_W'(1)) >= height_reg;

    always_comb begin
        fmt_next    = fmt_reg;
        width_next  = width_reg;
        height_next = height_reg;
        pad_next    = pad_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        base_next   = base_reg;
        if (cfg_we) begin
            case (cfg_addr)
                tfr_pkg::CFG_FORMAT: begin
                    fmt_next = tfr_pkg::fmt_t'(cfg_wdata[1:0]);
                end
                tfr_pkg::CFG_WIDTH: begin
                    width_next = cfg_wdata;
                    pad_next   = pad_of(cfg_wdata);
                end
                tfr_pkg::CFG_HEIGHT: begin
                    height_next = cfg_wdata;
                end
                default: begin
                end
            endcase
            // any known register restarts the image
            if (cfg_addr == tfr_pkg::CFG_FORMAT || cfg_addr == tfr_pkg::CFG_WIDTH
                || cfg_addr == tfr_pkg::CFG_HEIGHT) begin
                col_next  = '0;
                row_next  = '0;
                base_next = '0;
            end
        end else if (accept && is_texel && !size_err) begin
            if (col_last) begin
                col_next = '0;
                if (row_last) begin
                    row_next  = '0;
                    base_next = '0;
                end else begin
                    row_next  = row_reg + tfr_pkg::POS_W'(1);
                    base_next = base_reg + tfr_pkg::IDX_W'(pad_reg);
                end
            end else begin
                col_next = col_reg + tfr_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg    <= tfr_pkg::FMT_RGBA32;
            width_reg  <= tfr_pkg::DIM_W'(1);
            height_reg <= tfr_pkg::DIM_W'(1);
            pad_reg    <= tfr_pkg::DIM_W'(tfr_pkg::MIN_DIM);
            col_reg    <= '0;
            row_reg    <= '0;
            base_reg   <= '0;
        end else begin
            fmt_reg    <= fmt_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            pad_reg    <= pad_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            base_reg   <= base_next;
        end
    end

    always_comb begin
        q_entry.func        = tfr_pkg::func_t'(s_func);
        q_entry.fmt         = fmt_reg;
        q_entry.status      = 1'b0;
        q_entry.last        = 1'b0;
        q_entry.pixel_index = '0;
        q_entry.data        = s_texel_data;
        if (!is_texel) begin
            q_entry.data = {8'd0, s_palette_color, s_palette_index};
        end else if (size_err) begin
            q_entry.status = 1'b1;
        end else begin
            q_entry.pixel_index = base_reg + tfr_pkg::IDX_W'(col_reg);
            q_entry.last        = col_last && row_last;
        end
    end

    assign q_push = accept;

endmodule

FILE: design/tfr_queue.sv
// Short FIFO decoupling the front end from the conversion back end.
module tfr_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tfr_pkg::entry_t  push_entry,
    output logic             push_ready,
    output logic             pop_valid,
    output tfr_pkg::entry_t  pop_entry,
    input  logic             pop_ready
);

    tfr_pkg::entry_t              slot_reg [tfr_pkg::QDEPTH];
    logic [tfr_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [tfr_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [tfr_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                         pop;

    assign push_ready = (cnt_reg != tfr_pkg::QCNT_W'(tfr_pkg::QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + tfr_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + tfr_pkg::QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + tfr_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - tfr_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: design/tfr_back.sv
// Back end: palette store, palette read stage and colour expansion into the output register.
module tfr_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  tfr_pkg::entry_t             q_entry,
    output logic                        q_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tfr_pkg::IDX_W-1:0]   m_pixel_index,
    output logic [7:0]                  m_red,
    output logic [7:0]                  m_green,
    output logic [7:0]                  m_blue,
    output logic [7:0]                  m_alpha,
    output logic                        m_last_texel,
    output logic                        m_status
);

    function automatic logic [7:0] widen5(input logic [4:0] f);
        return {f, f[4:2]};
    endfunction

    logic [15:0]          pal_mem [tfr_pkg::PAL_DEPTH];
    logic [15:0]          pal_rd_reg;
    logic                 b_valid_reg, b_valid_next;
    tfr_pkg::entry_t      b_entry_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [tfr_pkg::IDX_W-1:0] idx_reg;
    logic [7:0]           red_reg, green_reg, blue_reg, alpha_reg;
    logic                 last_reg, status_reg;

    logic                 c_ready;
    logic                 b_ready;
    logic                 pop;
    logic                 pal_wr;
    logic [15:0]          c16;
    logic [7:0]           red_c, green_c, blue_c, alpha_c;

    assign c_ready = !m_valid_reg || m_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign q_ready = b_ready;
    assign pop     = q_valid && b_ready;
    assign pal_wr  = pop && (q_entry.func == tfr_pkg::FUNC_PAL_WRITE);

    // palette writes end here; only texels move on to the read stage
    assign b_valid_next = b_ready ? (q_valid && q_entry.func == tfr_pkg::FUNC_TEXEL)
                                  : b_valid_reg;
    assign m_valid_next = c_ready ? b_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (pal_wr) begin
            pal_mem[q_entry.data[tfr_pkg::PAL_AW-1:0]] <= q_entry.data[tfr_pkg::PAL_AW +: 16];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            pal_rd_reg  <= pal_mem[q_entry.data[tfr_pkg::PAL_AW-1:0]];
            b_entry_reg <= q_entry;
        end
    end

    always_comb begin
        c16 = (b_entry_reg.fmt == tfr_pkg::FMT_CI8) ? pal_rd_reg : b_entry_reg.data[15:0];
        case (b_entry_reg.fmt)
            tfr_pkg::FMT_RGBA32: begin
                red_c   = b_entry_reg.data[31:24];
                green_c = b_entry_reg.data[23:16];
                blue_c  = b_entry_reg.data[15:8];
                alpha_c = b_entry_reg.data[7:0];
            end
            tfr_pkg::FMT_RGBA16, tfr_pkg::FMT_CI8: begin
                red_c   = widen5(c16[15:11]);
                green_c = widen5(c16[10:6]);
                blue_c  = widen5(c16[5:1]);
                alpha_c = c16[0] ? 8'hFF : 8'h00;
            end
            default: begin
                // nibble times 17 is the nibble repeated
                red_c   = {b_entry_reg.data[7:4], b_entry_reg.data[7:4]};
                green_c = red_c;
                blue_c  = red_c;
                alpha_c = {b_entry_reg.data[3:0], b_entry_reg.data[3:0]};
            end
        endcase
        if (b_entry_reg.status) begin
            red_c   = '0;
            green_c = '0;
            blue_c  = '0;
            alpha_c = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && b_valid_reg) begin
            idx_reg    <= b_entry_reg.pixel_index;
            red_reg    <= red_c;
            green_reg  <= green_c;
            blue_reg   <= blue_c;
            alpha_reg  <= alpha_c;
            last_reg   <= b_entry_reg.last;
            status_reg <= b_entry_reg.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_index = idx_reg;
    assign m_red         = red_reg;
    assign m_green       = green_reg;
    assign m_blue        = blue_reg;
    assign m_alpha       = alpha_reg;
    assign m_last_texel  = last_reg;
    assign m_status      = status_reg;

endmodule

FILE: design/tfr_checker.sv
// Port-level checks for the converter top level, bound in below.
module tfr_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_func,
    input logic [7:0]                  s_palette_index,
    input logic [15:0]                 s_palette_color,
    input logic [31:0]                 s_texel_data,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [tfr_pkg::IDX_W-1:0]   m_pixel_index,
    input logic [7:0]                  m_red,
    input logic [7:0]                  m_green,
    input logic [7:0]                  m_blue,
    input logic [7:0]                  m_alpha,
    input logic                        m_last_texel,
    input logic                        m_status
);

    // waiting input transfer keeps its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_func) && $stable(s_palette_index)
            && $stable(s_palette_color) && $stable(s_texel_data))
        else $error("input changed while waiting");

    // stalled result holds until the transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_index) && $stable(m_red)
            && $stable(m_green) && $stable(m_blue) && $stable(m_alpha)
            && $stable(m_last_texel) && $stable(m_status))
        else $error("result changed while stalled");

    // size error results carry nothing else
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_pixel_index == '0 && m_red == '0 && m_green == '0
            && m_blue == '0 && m_alpha == '0 && !m_last_texel)
        else $error("size error result with non-zero fields");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready straight after reset");

endmodule

bind texel_format_to_rgba8_top tfr_checker u_tfr_checker (.*);

FILE: test/texel_format_to_rgba8_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the texel converter: predicts every pixel and checks the result channel.
module texel_format_to_rgba8_checker
    import tfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [DIM_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_func,
    input  logic [7:0]        s_palette_index,
    input  logic [15:0]       s_palette_color,
    input  logic [31:0]       s_texel_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [IDX_W-1:0]  m_pixel_index,
    input  logic [7:0]        m_red,
    input  logic [7:0]        m_green,
    input  logic [7:0]        m_blue,
    input  logic [7:0]        m_alpha,
    input  logic              m_last_texel,
    input  logic              m_status,
    output int                error_count,
    output int                pixels_waiting,
    output int                pixels_checked,
    output int                images_done
);

    typedef struct packed {
        logic [IDX_W-1:0] pixel_index;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic             last_texel;
        logic             status;
    } rgba8_pixel_t;

    fmt_t             fmt_q;
    logic [DIM_W-1:0] width_q;
    logic [DIM_W-1:0] height_q;
    int unsigned      col_q;
    int unsigned      row_q;
    logic [IDX_W-1:0] row_base_q;
    logic [15:0]      palette_q [PAL_DEPTH];
    rgba8_pixel_t     expected_pixels [$];

    // 5-bit channels widen by repeating their top bits; alpha bit goes to 0 or 255
    function automatic logic [31:0] rgba_from_5551(input logic [15:0] c);
        return {c[15:11], c[15:13], c[10:6], c[10:8], c[5:1], c[5:3], {8{c[0]}}};
    endfunction

    function automatic logic [IDX_W-1:0] row_pitch(input logic [DIM_W-1:0] w);
        int unsigned p;
        p = MIN_DIM;
        while (p < w) p = p << 1;
        return IDX_W'(p);
    endfunction

    task automatic report(input string msg);
        $display("[%0t] %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", what, got, want));
        end
    endtask

    task automatic convert_texel(input logic [31:0] data, output rgba8_pixel_t px);
        logic [31:0] rgba;
        px = '0;
        if (width_q == 0 || width_q > MAX_DIM || height_q == 0 || height_q > MAX_DIM) begin
            // size error: status only, position held
            px.status = 1'b1;
        end else begin
            case (fmt_q)
                FMT_RGBA32: rgba = data;
                FMT_RGBA16: rgba = rgba_from_5551(data[15:0]);
                FMT_CI8:    rgba = rgba_from_5551(palette_q[data[7:0]]);
                default:    rgba = {{3{data[7:4], data[7:4]}}, data[3:0], data[3:0]};
            endcase
            {px.red, px.green, px.blue, px.alpha} = rgba;
            px.pixel_index = row_base_q + IDX_W'(col_q);
            if (col_q + 1 >= width_q) begin
                col_q = 0;
                if (row_q + 1 >= height_q) begin
                    px.last_texel = 1'b1;
                    row_q = 0;
                    row_base_q = '0;
                end else begin
                    row_q++;
                    row_base_q = row_base_q + row_pitch(width_q);
                end
            end else begin
                col_q++;
            end
        end
    endtask

    always @(posedge aclk) begin : monitor
        rgba8_pixel_t px;
        rgba8_pixel_t want;
        if (!aresetn) begin
            fmt_q = FMT_RGBA32;
            width_q = 1;
            height_q = 1;
            col_q = 0;
            row_q = 0;
            row_base_q = '0;
            expected_pixels.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_FORMAT: fmt_q = fmt_t'(cfg_wdata[1:0]);
                    CFG_WIDTH:  width_q = cfg_wdata;
                    CFG_HEIGHT: height_q = cfg_wdata;
                    default: ;
                endcase
                if (cfg_addr inside {CFG_FORMAT, CFG_WIDTH, CFG_HEIGHT}) begin
                    col_q = 0;
                    row_q = 0;
                    row_base_q = '0;
                end
            end
            if (s_valid && s_ready) begin
                if (func_t'(s_func) == FUNC_PAL_WRITE) begin
                    palette_q[s_palette_index] = s_palette_color;
                end else begin
                    convert_texel(s_texel_data, px);
                    expected_pixels.push_back(px);
                end
            end
            if (m_valid && m_ready) begin
                pixels_checked++;
                if (m_last_texel) images_done++;
                if (expected_pixels.size() == 0) begin
                    report($sformatf("result transfer with no pixel expected (index 0x%0h)",
                                     m_pixel_index));
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_index", 32'(m_pixel_index), 32'(want.pixel_index));
                    check_field("red", 32'(m_red), 32'(want.red));
                    check_field("green", 32'(m_green), 32'(want.green));
                    check_field("blue", 32'(m_blue), 32'(want.blue));
                    check_field("alpha", 32'(m_alpha), 32'(want.alpha));
                    check_field("last_texel", 32'(m_last_texel), 32'(want.last_texel));
                    check_field("status", 32'(m_status), 32'(want.status));
                end
            end
        end
        pixels_waiting = expected_pixels.size();
    end

endmodule

FILE: test/texel_format_to_rgba8_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the texel converter: stimulus, flow control and verdict.
module texel_format_to_rgba8_top_tb;
    import tfr_pkg::*;

    localparam logic [CFG_AW-1:0] CFG_SPARE = 2'd3;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [CFG_AW-1:0]  cfg_addr;
    logic [DIM_W-1:0]   cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    func_t              s_func;
    logic [7:0]         s_palette_index;
    logic [15:0]        s_palette_color;
    logic [31:0]        s_texel_data;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [IDX_W-1:0]   m_pixel_index;
    logic [7:0]         m_red;
    logic [7:0]         m_green;
    logic [7:0]         m_blue;
    logic [7:0]         m_alpha;
    logic               m_last_texel;
    logic               m_status;

    int error_count;
    int pixels_waiting;
    int pixels_checked;
    int images_done;

    int gap_pct;
    int stall_pct;
    int items_sent;
    int palette_loads;
    int settings_used;
    bit palette_loaded [PAL_DEPTH];

    texel_format_to_rgba8_top dut (.*);

    texel_format_to_rgba8_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("timeout: transfers stalled");
        $display("CHECKS FAILED");
        $finish;
    end

    // valid stays up between back-to-back items; it only drops for a gap
    task automatic send_item(input func_t func, input logic [7:0] pidx,
                             input logic [15:0] pcol, input logic [31:0] data);
        if ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_palette_index <= pidx;
        s_palette_color <= pcol;
        s_texel_data <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_texel(input logic [31:0] data);
        send_item(FUNC_TEXEL, 8'($urandom), 16'($urandom), data);
    endtask

    task automatic load_palette(input logic [7:0] idx, input logic [15:0] colour);
        palette_loaded[idx] = 1'b1;
        palette_loads++;
        send_item(FUNC_PAL_WRITE, idx, colour, $urandom);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pixels_waiting != 0) @(posedge aclk);
        // palette writes may still be in the pipe
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_image(input fmt_t f, input logic [DIM_W-1:0] w,
                             input logic [DIM_W-1:0] h);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_addr <= CFG_FORMAT;
        cfg_wdata <= DIM_W'(f);
        @(posedge aclk);
        cfg_addr <= CFG_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_addr <= CFG_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // ci8 texels only name entries that have been loaded
    task automatic send_random_texel(input fmt_t f);
        logic [31:0] d;
        logic [7:0]  ci;
        d = $urandom;
        if (f == FMT_CI8) begin
            ci = 8'($urandom);
            if (!palette_loaded[ci]) load_palette(ci, 16'($urandom));
            d[7:0] = ci;
        end
        send_texel(d);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 72) return DIM_W'($urandom_range(12, 1));
        else if (r < 86) return DIM_W'($urandom_range(40, 13));
        else if (r < 93) return DIM_W'($urandom_range(MAX_DIM, 1000));
        else if (r < 96) return '0;
        else return DIM_W'($urandom_range(2047, MAX_DIM + 1));
    endfunction

    // whole images (once or twice round) when w x h is at most 64, else a partial run
    task automatic run_random(input int n_items);
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        fmt_t             f;
        int               first;
        int               n;
        first = items_sent;
        while (items_sent - first < n_items) begin
            f = fmt_t'($urandom_range(3));
            w = pick_dim();
            h = pick_dim();
            set_image(f, w, h);
            if (w >= 1 && h >= 1 && int'(w) * int'(h) <= 64) begin
                n = int'(w) * int'(h) * $urandom_range(2, 1);
            end else begin
                n = $urandom_range(30, 1);
            end
            repeat (n) begin
                if ($urandom_range(99) < 6) load_palette(8'($urandom), 16'($urandom));
                send_random_texel(f);
            end
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_addr <= CFG_FORMAT;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_func <= FUNC_TEXEL;
        s_palette_index <= '0;
        s_palette_color <= '0;
        s_texel_data <= '0;
        gap_pct = 14;
        stall_pct = 78;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // rgba32 2 x 2: all-ones, all-zeros, mixed bytes; last flag on the fourth
        set_image(FMT_RGBA32, 2, 2);
        send_texel(32'hFFFF_FFFF);
        send_texel(32'h0000_0000);
        send_texel(32'h80FF_017F);
        send_texel(32'h5A5A_A5A5);
        // 5551 with junk above bit 15; width 2 wraps
        set_image(FMT_RGBA16, 2, 1);
        send_texel(32'hABCD_FFFF);
        send_texel(32'h5432_FFFE);
        send_texel(32'h0000_0001);
        // palette ends and one mixed entry, read back as single-texel images
        load_palette(8'h00, 16'hFFFF);
        load_palette(8'hFF, 16'h0000);
        load_palette(8'h5A, 16'h8421);
        set_image(FMT_CI8, 1, 1);
        send_texel(32'hFFFF_FF00);
        send_texel(32'h0000_00FF);
        send_texel(32'hC3C3_C35A);
        // ia8 nibble extremes; width 1 pads to the minimum pitch
        set_image(FMT_IA8, 1, 3);
        send_texel(32'h0000_00F0);
        send_texel(32'h0000_000F);
        send_texel(32'hFFFF_FFFF);
        // size errors: zero width, oversize width, oversize height
        set_image(FMT_RGBA32, 0, 1);
        send_texel($urandom);
        set_image(FMT_RGBA32, 2047, 1);
        send_texel($urandom);
        set_image(FMT_RGBA16, 4, DIM_W'(MAX_DIM + 1));
        send_texel($urandom);
        // largest legal image; the unused register index must not restart it
        set_image(FMT_RGBA32, DIM_W'(MAX_DIM), DIM_W'(MAX_DIM));
        send_texel($urandom);
        send_texel($urandom);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_addr <= CFG_SPARE;
        cfg_wdata <= '1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        send_texel($urandom);

        run_random(130);
        gap_pct = 78;
        stall_pct = 14;
        run_random(130);
        gap_pct = 0;
        stall_pct = 0;
        run_random(130);
        wait_drained();

        $display("%0d items sent (%0d palette loads) over %0d image settings",
                 items_sent, palette_loads, settings_used);
        $display("%0d pixels checked, %0d images completed", pixels_checked, images_done);
        if (error_count == 0 && pixels_waiting == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
